### rtl/core/urc_pkg.sv
// ----------------------------------------------------------------------------
// urc_pkg
// Shared types, constants and helper functions of the ultrasonic range
// controller.
// ----------------------------------------------------------------------------
package urc_pkg;

    // Width of the phase and echo counters.
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes (byte address is four times the index).
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_TRIGGER      = 2'd0;
    localparam logic [1:0] REG_RISE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_FALL_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_GAP          = 2'd3;

    // Register reset values.
    localparam logic [7:0]  RST_TRIGGER      = 8'd10;
    localparam logic [15:0] RST_RISE_TIMEOUT = 16'd10000;
    localparam logic [15:0] RST_FALL_TIMEOUT = 16'd50000;
    localparam logic [15:0] RST_GAP          = 16'd1000;

    // Centimetres = floor(width * 17 / 1000), done as a multiply by a
    // rounded-up reciprocal (17 * 2^36 / 1000) and a shift. The rounding
    // error stays below 1/1000 for widths up to 24 bits.
    localparam int CM_MUL_W = 31;
    localparam logic [CM_MUL_W-1:0] CM_MUL = 31'd1168231105;
    localparam int CM_SHIFT = 36;
    localparam int CM_FULL_W = CNT_W + CM_MUL_W - CM_SHIFT;
    localparam int CM_W = 11;
    localparam logic [CM_W-1:0] CM_SAT = 11'd2047;

    // Inches = floor(cm * 50 / 127), multiply by ceil(50 * 2^20 / 127).
    localparam int IN_MUL_W = 19;
    localparam logic [IN_MUL_W-1:0] IN_MUL = 19'd412826;
    localparam int IN_SHIFT = 20;
    localparam int IN_FULL_W = CM_W + IN_MUL_W - IN_SHIFT;
    localparam int IN_W = 9;
    localparam logic [IN_W-1:0] IN_SAT = 9'd511;

    // Unit codes placed in the packed byte.
    localparam logic [7:0] CODE_CM   = 8'd2;
    localparam logic [7:0] CODE_INCH = 8'd1;

    // Ranging cycle phases.
    typedef enum logic [3:0] {
        PH_TRIGGER   = 4'b0001,
        PH_WAIT_RISE = 4'b0010,
        PH_MEASURE   = 4'b0100,
        PH_GAP       = 4'b1000
    } t_phase;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0]  trigger_us;
        logic [15:0] rise_timeout_us;
        logic [15:0] fall_timeout_us;
        logic [15:0] gap_us;
    } t_cfg;

    // One tick's outcome leaving the sequencer, before unit conversion.
    typedef struct packed {
        logic             valid;
        logic             trigger_level;
        logic             report_valid;
        logic [CNT_W-1:0] width;
        logic             inch_mode;
    } t_tick;

    // One tick's outcome after centimetre conversion.
    typedef struct packed {
        logic            valid;
        logic            trigger_level;
        logic            report_valid;
        logic [CM_W-1:0] distance_cm;
        logic            inch_mode;
    } t_tick_cm;

    // One finished result.
    typedef struct packed {
        logic            trigger_level;
        logic            report_valid;
        logic [7:0]      packed_byte;
        logic [CM_W-1:0] distance_cm;
        logic [IN_W-1:0] distance_inch;
        logic            inch_mode;
    } t_result;

    // Counter increment that holds at the top of the range.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? v : v + 1'b1;
        return r;
    endfunction

    // A limit register, with zero raised to one where asked, clipped to the
    // counter range.
    function automatic logic [CNT_W-1:0] clip_limit(input logic [15:0] v,
                                                    input logic at_least_one);
        logic [15:0] t;
        logic [CNT_W-1:0] r;
        t = (at_least_one && (v == 16'd0)) ? 16'd1 : v;
        if (32'(t) > 32'(CNT_MAX)) begin
            r = CNT_MAX;
        end else begin
            r = CNT_W'(t);
        end
        return r;
    endfunction

endpackage

### rtl/core/urc_in_if.sv
// ----------------------------------------------------------------------------
// urc_in_if
// Tick channel: one request per microsecond with the echo level and button.
// ----------------------------------------------------------------------------
interface urc_in_if;
    logic valid;
    logic ready;
    logic echo_level;
    logic button_press;

    modport source (output valid, output echo_level, output button_press, input ready);
    modport sink   (input valid, input echo_level, input button_press, output ready);
endinterface

### rtl/core/urc_out_if.sv
// ----------------------------------------------------------------------------
// urc_out_if
// Result channel: one request per tick with trigger level and report fields.
// ----------------------------------------------------------------------------
interface urc_out_if import urc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            trigger_level;
    logic            report_valid;
    logic [7:0]      packed_byte;
    logic [CM_W-1:0] distance_cm;
    logic [IN_W-1:0] distance_inch;
    logic            inch_mode;

    modport source (output valid, output trigger_level, output report_valid,
                    output packed_byte, output distance_cm, output distance_inch,
                    output inch_mode, input ready);
    modport sink   (input valid, input trigger_level, input report_valid,
                    input packed_byte, input distance_cm, input distance_inch,
                    input inch_mode, output ready);
endinterface

### rtl/core/urc_cfg.sv
// ----------------------------------------------------------------------------
// urc_cfg
// APB register file holding the trigger length, both timeouts and the gap.
// ----------------------------------------------------------------------------
module urc_cfg import urc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_us      <= RST_TRIGGER;
            r_cfg.rise_timeout_us <= RST_RISE_TIMEOUT;
            r_cfg.fall_timeout_us <= RST_FALL_TIMEOUT;
            r_cfg.gap_us          <= RST_GAP;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TRIGGER:      r_cfg.trigger_us      <= pwdata[7:0];
                REG_RISE_TIMEOUT: r_cfg.rise_timeout_us <= pwdata[15:0];
                REG_FALL_TIMEOUT: r_cfg.fall_timeout_us <= pwdata[15:0];
                REG_GAP:          r_cfg.gap_us          <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Read data, zero-extended to the bus width.
    always_comb begin
        case (reg_idx)
            REG_TRIGGER:      prdata = {24'd0, r_cfg.trigger_us};
            REG_RISE_TIMEOUT: prdata = {16'd0, r_cfg.rise_timeout_us};
            REG_FALL_TIMEOUT: prdata = {16'd0, r_cfg.fall_timeout_us};
            REG_GAP:          prdata = {16'd0, r_cfg.gap_us};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

### rtl/core/urc_seq.sv
// ----------------------------------------------------------------------------
// urc_seq
// Input register and ranging sequencer: trigger, wait for echo, measure the
// echo width, report and gap, one tick per cycle while enabled.
// ----------------------------------------------------------------------------
module urc_seq import urc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic i_echo,
    input  logic i_button,
    input  t_cfg i_cfg,
    output t_tick o_tick
);

    // Input register.
    logic r_in_valid;
    logic r_in_echo;
    logic r_in_button;

    // Sequencer state.
    t_phase           r_phase,   n_phase;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [CNT_W-1:0] r_width,   n_width;
    logic             r_pending, n_pending;
    logic             r_unit,    n_unit;

    // Tick result register.
    t_tick r_tick, n_tick;

    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] width_inc;
    logic [CNT_W-1:0] lim_trigger;
    logic [CNT_W-1:0] lim_rise;
    logic [CNT_W-1:0] lim_fall;
    logic [CNT_W-1:0] lim_gap;
    logic             do_report;
    logic [CNT_W-1:0] rpt_width;
    logic             step;

    assign step        = i_en && r_in_valid;
    assign count_inc   = sat_inc(r_count);
    assign width_inc   = sat_inc(r_width);
    assign lim_trigger = clip_limit({8'd0, i_cfg.trigger_us}, 1'b1);
    assign lim_rise    = clip_limit(i_cfg.rise_timeout_us, 1'b1);
    assign lim_fall    = clip_limit(i_cfg.fall_timeout_us, 1'b1);
    assign lim_gap     = clip_limit(i_cfg.gap_us, 1'b0);
    assign o_tick      = r_tick;

    // Next-state logic for one tick.
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_width   = r_width;
        n_pending = r_pending | r_in_button;
        n_unit    = r_unit;
        do_report = 1'b0;
        rpt_width = '0;
        n_tick    = '0;

        case (r_phase)
            PH_TRIGGER: begin
                n_tick.trigger_level = 1'b1;
                n_count = count_inc;
                if (count_inc >= lim_trigger) begin
                    n_phase = PH_WAIT_RISE;
                    n_count = '0;
                end
            end
            PH_WAIT_RISE: begin
                if (r_in_echo) begin
                    n_phase = PH_MEASURE;
                    n_count = '0;
                    n_width = '0;
                end else begin
                    n_count = count_inc;
                    if (count_inc >= lim_rise) begin
                        n_width   = '0;
                        do_report = 1'b1;
                    end
                end
            end
            PH_MEASURE: begin
                if (r_in_echo) begin
                    n_width = width_inc;
                    if (width_inc >= lim_fall) begin
                        do_report = 1'b1;
                        rpt_width = width_inc;
                    end
                end else begin
                    do_report = 1'b1;
                    rpt_width = r_width;
                end
            end
            PH_GAP: begin
                n_count = count_inc;
                if (count_inc >= lim_gap) begin
                    n_phase = PH_TRIGGER;
                    n_count = '0;
                end
            end
            default: begin
                n_phase = PH_TRIGGER;
                n_count = '0;
            end
        endcase

        // A report applies any pending unit toggle and starts the gap, or the trigger when the gap is zero.
        if (do_report) begin
            if (n_pending) begin
                n_unit    = ~r_unit;
                n_pending = 1'b0;
            end
            n_count = '0;
            n_phase = (i_cfg.gap_us == 16'd0) ? PH_TRIGGER : PH_GAP;
        end

        n_tick.valid        = r_in_valid;
        n_tick.report_valid = do_report;
        n_tick.width        = rpt_width;
        n_tick.inch_mode    = n_unit;
    end

    // Control registers and the tick result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_tick.valid <= 1'b0;
            r_phase      <= PH_TRIGGER;
            r_count      <= '0;
            r_width      <= '0;
            r_pending    <= 1'b0;
            r_unit       <= 1'b0;
        end else if (i_en) begin
            r_in_valid <= i_valid;
            r_tick     <= n_tick;
            if (step) begin
                r_phase   <= n_phase;
                r_count   <= n_count;
                r_width   <= n_width;
                r_pending <= n_pending;
                r_unit    <= n_unit;
            end
        end
    end

    // Input payload registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in_echo   <= i_echo;
            r_in_button <= i_button;
        end
    end

endmodule

### rtl/core/urc_conv.sv
// ----------------------------------------------------------------------------
// urc_conv
// Unit conversion: echo width to centimetres (registered), then inches and
// the packed report byte.
// ----------------------------------------------------------------------------
module urc_conv import urc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_tick   i_tick,
    output logic    o_push,
    output t_result o_result
);

    t_tick_cm r_cm;

    logic [CNT_W+CM_MUL_W-1:0] cm_prod;
    logic [CM_FULL_W-1:0]      cm_full;
    logic [CM_W-1:0]           cm_sat;
    logic [CM_W+IN_MUL_W-1:0]  in_prod;
    logic [IN_FULL_W-1:0]      in_full;
    logic [IN_W-1:0]           in_sat;
    logic [CM_W-1:0]           value;
    logic [7:0]                code;
    logic [10:0]               byte_sum;

    // Centimetres by reciprocal multiply, saturated to the output range.
    always_comb begin
        cm_prod = (CNT_W+CM_MUL_W)'(i_tick.width) * (CNT_W+CM_MUL_W)'(CM_MUL);
        cm_full = cm_prod[CNT_W+CM_MUL_W-1:CM_SHIFT];
        if (32'(cm_full) > 32'(CM_SAT)) begin
            cm_sat = CM_SAT;
        end else begin
            cm_sat = CM_W'(cm_full);
        end
    end

    // Centimetre stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cm.valid <= 1'b0;
        end else if (i_en) begin
            r_cm.valid         <= i_tick.valid;
            r_cm.trigger_level <= i_tick.trigger_level;
            r_cm.report_valid  <= i_tick.report_valid;
            r_cm.distance_cm   <= cm_sat;
            r_cm.inch_mode     <= i_tick.inch_mode;
        end
    end

    // Inches by reciprocal multiply, saturated to the output range.
    always_comb begin
        in_prod = (CM_W+IN_MUL_W)'(r_cm.distance_cm) * (CM_W+IN_MUL_W)'(IN_MUL);
        in_full = in_prod[CM_W+IN_MUL_W-1:IN_SHIFT];
        if (32'(in_full) > 32'(IN_SAT)) begin
            in_sat = IN_SAT;
        end else begin
            in_sat = IN_W'(in_full);
        end
    end

    // Packed byte: low byte of the value times ten plus the unit code.
    always_comb begin
        value    = r_cm.inch_mode ? CM_W'(in_sat) : r_cm.distance_cm;
        code     = r_cm.inch_mode ? CODE_INCH : CODE_CM;
        byte_sum = {value[7:0], 3'b000} + {2'b00, value[7:0], 1'b0} + {3'b000, code};
    end

    // Result item; report fields are zero on ticks without a report.
    always_comb begin
        o_push                 = i_en && r_cm.valid;
        o_result.trigger_level = r_cm.trigger_level;
        o_result.report_valid  = r_cm.report_valid;
        o_result.inch_mode     = r_cm.inch_mode;
        if (r_cm.report_valid) begin
            o_result.packed_byte   = byte_sum[7:0];
            o_result.distance_cm   = r_cm.distance_cm;
            o_result.distance_inch = in_sat;
        end else begin
            o_result.packed_byte   = 8'd0;
            o_result.distance_cm   = '0;
            o_result.distance_inch = '0;
        end
    end

endmodule

### rtl/core/urc_outq.sv
// ----------------------------------------------------------------------------
// urc_outq
// Two-entry result queue that decouples the pipeline from the receiver.
// ----------------------------------------------------------------------------
module urc_outq import urc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_result      i_result,
    output logic         o_full,
    urc_out_if.source    o_out
);

    t_result    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;
    t_result    head;

    assign o_full = (r_cnt == 2'd2);
    assign pop    = o_out.valid && o_out.ready;
    assign head   = r_q[r_rp];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_result;
        end
    end

    // Head entry on the result channel.
    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.trigger_level = head.trigger_level;
    assign o_out.report_valid  = head.report_valid;
    assign o_out.packed_byte   = head.packed_byte;
    assign o_out.distance_cm   = head.distance_cm;
    assign o_out.distance_inch = head.distance_inch;
    assign o_out.inch_mode     = head.inch_mode;

endmodule

### rtl/core/ultrasonic_range_controller.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_controller
// HC-SR04 style ranging controller: trigger pulse, echo timing with
// timeouts, conversion to centimetres and inches, unit toggle, packed byte.
//
// Usage:
//   i_in carries one request per microsecond tick (echo level, button event).
//   o_out returns exactly one request per tick: trigger level to drive, and
//   on report ticks the distance in both units and the packed byte.
//   The APB port holds trigger length, rise and fall timeouts and the gap;
//   write it only while no tick is in flight.
// Pipeline:
//   One tick is accepted every cycle while the result queue has room. A
//   tick passes through the input register, the sequencer register, the
//   centimetre multiplier register and the result queue before its result
//   is offered on o_out.
// Reset:
//   Synchronous, active low. Registers return to their defaults, the
//   sequencer restarts in the trigger phase in centimetre mode, and all
//   in-flight ticks are dropped.
// Stall:
//   A two-entry result queue absorbs a stalled receiver; once it is full
//   the whole pipeline holds and i_in.ready drops until a result is taken.
// ----------------------------------------------------------------------------
module ultrasonic_range_controller import urc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    urc_in_if.sink                i_in,
    urc_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg    cfg;
    t_tick   tick;
    t_result result;
    logic    push;
    logic    full;
    logic    en;

    // The pipeline moves whenever the result queue has room.
    assign en         = !full;
    assign i_in.ready = en;

    urc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    urc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_echo   (i_in.echo_level),
        .i_button (i_in.button_press),
        .i_cfg    (cfg),
        .o_tick   (tick)
    );

    urc_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_tick   (tick),
        .o_push   (push),
        .o_result (result)
    );

    urc_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_full   (full),
        .o_out    (o_out)
    );

endmodule

### tb/sv/tb_ultrasonic_range_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_controller
// Self-checking bench for the ranging controller. Microsecond ticks carry
// shaped echo pulses and button events. A scoreboard class tracks its own
// copy of the ranging sequence and checks every result request field by
// field. Register sets run from all-zero and minimum values through random
// short cycles to the longest trigger pulse with no gap. The result channel
// stalls at random.
// ----------------------------------------------------------------------------
module tb_ultrasonic_range_controller;
    import urc_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_ITEMS    = 145;
    localparam int SHOW_MAX     = 10;
    localparam int DIR_N        = 24;

    localparam logic [1:0] REG_LIST [4] = '{REG_TRIGGER, REG_RISE_TIMEOUT,
                                            REG_FALL_TIMEOUT, REG_GAP};

    // Short scripted sequence: echo ignored during trigger and gap, rise
    // timeout, immediate rise, fall timeout, zero-width echo, and button
    // presses both ahead of a report and on the report tick itself.
    // Bit i holds the value for tick i.
    localparam logic [DIR_N-1:0] DIR_ECHO = 24'b0110_0001_0001_1111_0010_0001;
    localparam logic [DIR_N-1:0] DIR_BTN  = 24'b0101_0000_0001_0000_0000_1000;

    // Tracks the ranging sequence and holds the results still to arrive.
    class range_scoreboard;
        logic [7:0]       trig_us;
        logic [15:0]      rise_us;
        logic [15:0]      fall_us;
        logic [15:0]      gap_us;
        t_phase           phase;
        logic [CNT_W-1:0] phase_cnt;
        logic [CNT_W-1:0] echo_cnt;
        logic             toggle_armed;
        logic             unit_inch;
        t_result          due_results[$];
        int unsigned      fails;
        int unsigned      ticks;
        int unsigned      reports;
        int unsigned      inch_reports;
        int unsigned      rise_timeouts;
        int unsigned      fall_timeouts;
        int unsigned      max_cm;

        function new();
            trig_us       = RST_TRIGGER;
            rise_us       = RST_RISE_TIMEOUT;
            fall_us       = RST_FALL_TIMEOUT;
            gap_us        = RST_GAP;
            phase         = PH_TRIGGER;
            phase_cnt     = '0;
            echo_cnt      = '0;
            toggle_armed  = 1'b0;
            unit_inch     = 1'b0;
            fails         = 0;
            ticks         = 0;
            reports       = 0;
            inch_reports  = 0;
            rise_timeouts = 0;
            fall_timeouts = 0;
            max_cm        = 0;
        endfunction

        function void complain(string msg);
            fails++;
            if (fails <= SHOW_MAX) begin
                $display("tb: mismatch: %s", msg);
            end
        endfunction

        // Writes keep only the register's own width.
        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_TRIGGER:      trig_us = value[7:0];
                REG_RISE_TIMEOUT: rise_us = value[15:0];
                REG_FALL_TIMEOUT: fall_us = value[15:0];
                default:          gap_us  = value[15:0];
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_TRIGGER:      return 32'(trig_us);
                REG_RISE_TIMEOUT: return 32'(rise_us);
                REG_FALL_TIMEOUT: return 32'(fall_us);
                default:          return 32'(gap_us);
            endcase
        endfunction

        // Counters hold at full scale.
        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        // A zero limit counts as one where the phase must last a tick.
        function logic [CNT_W-1:0] limit_of(logic [15:0] v, bit nonzero);
            if (nonzero && v == 16'd0) begin
                return CNT_W'(1);
            end
            if (32'(v) > 32'(CNT_MAX)) begin
                return CNT_MAX;
            end
            return CNT_W'(v);
        endfunction

        // Closes a measurement: applies a pending unit toggle, converts the
        // width and moves on to the gap or straight back to the trigger.
        function t_result reported(logic [CNT_W-1:0] width);
            t_result     r;
            int unsigned cm;
            int unsigned inch;
            int unsigned value;
            r = '0;
            if (toggle_armed) begin
                unit_inch    = ~unit_inch;
                toggle_armed = 1'b0;
            end
            cm = (32'(width) * 17) / 1000;
            if (cm > CM_SAT) begin
                cm = 32'(CM_SAT);
            end
            inch = (cm * 50) / 127;
            if (inch > IN_SAT) begin
                inch = 32'(IN_SAT);
            end
            value = unit_inch ? inch : cm;
            r.report_valid  = 1'b1;
            r.packed_byte   = 8'((value % 256) * 10 + (unit_inch ? CODE_INCH : CODE_CM));
            r.distance_cm   = CM_W'(cm);
            r.distance_inch = IN_W'(inch);
            phase_cnt = '0;
            phase     = (gap_us == 16'd0) ? PH_TRIGGER : PH_GAP;
            reports++;
            if (unit_inch) begin
                inch_reports++;
            end
            if (cm > max_cm) begin
                max_cm = cm;
            end
            return r;
        endfunction

        // Advances the sequence by one accepted tick and queues its result.
        function void note_tick(logic echo, logic button);
            t_result r;
            r = '0;
            ticks++;
            toggle_armed = toggle_armed | button;
            case (phase)
                PH_TRIGGER: begin
                    r.trigger_level = 1'b1;
                    phase_cnt = bump(phase_cnt);
                    if (phase_cnt >= limit_of(16'(trig_us), 1'b1)) begin
                        phase     = PH_WAIT_RISE;
                        phase_cnt = '0;
                    end
                end
                PH_WAIT_RISE: begin
                    if (echo) begin
                        phase     = PH_MEASURE;
                        phase_cnt = '0;
                        echo_cnt  = '0;
                    end else begin
                        phase_cnt = bump(phase_cnt);
                        if (phase_cnt >= limit_of(rise_us, 1'b1)) begin
                            echo_cnt = '0;
                            rise_timeouts++;
                            r = reported('0);
                        end
                    end
                end
                PH_MEASURE: begin
                    if (echo) begin
                        echo_cnt = bump(echo_cnt);
                        if (echo_cnt >= limit_of(fall_us, 1'b1)) begin
                            fall_timeouts++;
                            r = reported(echo_cnt);
                        end
                    end else begin
                        r = reported(echo_cnt);
                    end
                end
                default: begin
                    phase_cnt = bump(phase_cnt);
                    if (phase_cnt >= limit_of(gap_us, 1'b0)) begin
                        phase     = PH_TRIGGER;
                        phase_cnt = '0;
                    end
                end
            endcase
            r.inch_mode = unit_inch;
            due_results.push_back(r);
        endfunction

        // Compares one result request with the oldest one due.
        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                complain($sformatf("result %p arrived with nothing due", got));
                return;
            end
            want = due_results.pop_front();
            if (got.trigger_level !== want.trigger_level
                    || got.report_valid !== want.report_valid
                    || got.packed_byte !== want.packed_byte
                    || got.distance_cm !== want.distance_cm
                    || got.distance_inch !== want.distance_inch
                    || got.inch_mode !== want.inch_mode) begin
                complain($sformatf({"trig/rep/byte/cm/inch/mode expected ",
                                    "%0b/%0b/%0d/%0d/%0d/%0b, got %0b/%0b/%0d/%0d/%0d/%0b"},
                                   want.trigger_level, want.report_valid,
                                   want.packed_byte, want.distance_cm,
                                   want.distance_inch, want.inch_mode,
                                   got.trigger_level, got.report_valid,
                                   got.packed_byte, got.distance_cm,
                                   got.distance_inch, got.inch_mode));
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    urc_in_if  tick_if ();
    urc_out_if res_if ();

    range_scoreboard sb;

    bit          fast_run   = 1'b0;
    bit          calm_tx    = 1'b0;
    bit          plan_armed = 1'b0;
    bit          noisy      = 1'b0;
    int unsigned rise_wait  = 0;
    int unsigned high_len   = 0;
    int unsigned reg_sets   = 0;
    int unsigned quiet      = 0;

    ultrasonic_range_controller u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: too long without any request moving on either channel.
    always @(posedge i_clk) begin
        if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: random stalls per request, with calm stretches.
    initial begin : result_sink
        int      stall;
        bit      calm;
        int      n;
        t_result got;
        res_if.ready <= 1'b0;
        calm = 1'b0;
        n = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (n % 40 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            stall = (calm || fast_run) ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            got.trigger_level = res_if.trigger_level;
            got.report_valid  = res_if.report_valid;
            got.packed_byte   = res_if.packed_byte;
            got.distance_cm   = res_if.distance_cm;
            got.distance_inch = res_if.distance_inch;
            got.inch_mode     = res_if.inch_mode;
            sb.check_result(got);
            n++;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic reg_read(input logic [1:0] idx, output logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_regs();
        logic [31:0] got;
        foreach (REG_LIST[i]) begin
            reg_read(REG_LIST[i], got);
            if (got !== sb.reg_value(REG_LIST[i])) begin
                sb.complain($sformatf("register %0d reads %0h, expected %0h",
                                      REG_LIST[i], got, sb.reg_value(REG_LIST[i])));
            end
        end
    endtask

    // Waits until every result is home, then rewrites all four registers
    // with random junk above each register's width.
    task automatic apply_config(input logic [7:0] trig, input logic [15:0] rise,
                                input logic [15:0] fall, input logic [15:0] gap);
        tick_if.valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        reg_write(REG_TRIGGER,      {24'($urandom), trig});
        reg_write(REG_RISE_TIMEOUT, {16'($urandom), rise});
        reg_write(REG_FALL_TIMEOUT, {16'($urandom), fall});
        reg_write(REG_GAP,          {16'($urandom), gap});
        verify_regs();
        plan_armed = 1'b0;
        reg_sets++;
    endtask

    // Offers one tick after a random hold-off and waits for it to be taken.
    task automatic send_tick(input logic echo, input logic button);
        int hold;
        if (sb.ticks % 40 == 0) begin
            calm_tx = ($urandom_range(0, 3) == 0);
        end
        hold = (calm_tx || fast_run) ? 0 : $urandom_range(0, 18);
        if (hold > 0) begin
            tick_if.valid <= 1'b0;
            repeat (hold) @(posedge i_clk);
        end
        tick_if.valid        <= 1'b1;
        tick_if.echo_level   <= echo;
        tick_if.button_press <= button;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
        sb.note_tick(echo, button);
    endtask

    // Shapes the echo: each ranging cycle gets a rise delay and a pulse
    // length, mostly well inside the timeouts, sometimes past them, and now
    // and then a cycle of pure noise.
    task automatic make_tick(output logic echo, output logic button);
        int unsigned lim;
        int unsigned pick;
        button = ($urandom_range(0, 24) == 0);
        if (sb.phase == PH_TRIGGER || sb.phase == PH_GAP) begin
            plan_armed = 1'b0;
            echo = ($urandom_range(0, 7) == 0);
        end else begin
            if (!plan_armed) begin
                lim = (sb.rise_us == 16'd0) ? 1 : sb.rise_us;
                if ($urandom_range(0, 4) == 0 && lim <= 64) begin
                    rise_wait = lim + $urandom_range(0, 2);
                end else begin
                    rise_wait = $urandom_range(0, (lim > 30 ? 30 : lim) - 1);
                end
                lim  = (sb.fall_us == 16'd0) ? 1 : sb.fall_us;
                pick = $urandom_range(0, 9);
                if (pick < 2 && lim <= 400) begin
                    high_len = lim + $urandom_range(0, 2);
                end else if (pick < 5) begin
                    high_len = $urandom_range(1, lim > 400 ? 400 : lim);
                end else begin
                    high_len = $urandom_range(1, lim > 40 ? 40 : lim);
                end
                noisy      = ($urandom_range(0, 9) == 0);
                plan_armed = 1'b1;
            end
            if (noisy) begin
                echo = 1'($urandom_range(0, 1));
            end else if (rise_wait > 0) begin
                echo = 1'b0;
                rise_wait--;
            end else if (high_len > 0) begin
                echo = 1'b1;
                high_len--;
            end else begin
                echo = 1'b0;
            end
        end
    endtask

    initial begin : stimulus
        logic        e;
        logic        b;
        int unsigned n;
        sb = new();
        i_rst_n              <= 1'b0;
        tick_if.valid        <= 1'b0;
        tick_if.echo_level   <= 1'b0;
        tick_if.button_press <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        verify_regs();

        // Scripted sequence on a very short cycle.
        apply_config(8'd2, 16'd3, 16'd4, 16'd1);
        for (int i = 0; i < DIR_N; i++) begin
            send_tick(DIR_ECHO[i], DIR_BTN[i]);
        end

        // Random cycles: minimum limits, zero limits, then random short ones.
        for (int s = 0; s < 5; s++) begin
            case (s)
                0:       apply_config(8'd1, 16'd1, 16'd1, 16'd0);
                1:       apply_config(8'd0, 16'd0, 16'd0, 16'd0);
                default: apply_config(8'($urandom_range(1, 12)), 16'($urandom_range(1, 60)),
                                      16'($urandom_range(1, 400)),
                                      16'($urandom_range(0, 30)));
            endcase
            repeat (RUN_ITEMS) begin
                make_tick(e, b);
                send_tick(e, b);
            end
        end

        // Longest trigger pulse with no gap: an echo held until the fall
        // timeout, then a rise timeout.
        apply_config(8'd255, 16'd120, 16'd300, 16'd0);
        fast_run = 1'b1;
        while (sb.phase != PH_WAIT_RISE) send_tick(1'b0, $urandom_range(0, 99) == 0);
        n = sb.reports;
        while (sb.reports == n) send_tick(1'b1, $urandom_range(0, 99) == 0);
        while (sb.phase != PH_WAIT_RISE) send_tick(1'b0, $urandom_range(0, 99) == 0);
        n = sb.reports;
        while (sb.reports == n) send_tick(1'b0, $urandom_range(0, 99) == 0);
        fast_run = 1'b0;

        // Let the pipeline empty, then give stray results a chance to show.
        tick_if.valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d ticks over %0d register sets, %0d reports (%0d in inches)",
                 sb.ticks, reg_sets, sb.reports, sb.inch_reports);
        $display("tb: %0d rise timeouts, %0d fall timeouts, longest range %0d cm, %0d mismatches",
                 sb.rise_timeouts, sb.fall_timeouts, sb.max_cm, sb.fails);
        if (sb.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
